// File: hw/rtl/dbcs_pkg.sv
// Shared types and helpers for the double-byte code unit classifier.
package dbcs_pkg;

    localparam int unsigned DATA_W = 32;
    localparam int unsigned ADDR_W = 3;

    typedef enum logic [2:0] {
        PAGE_NONE   = 3'd0,
        PAGE_GBK    = 3'd1,
        PAGE_BIG5   = 3'd2,
        PAGE_SJIS   = 3'd3,
        PAGE_KOREAN = 3'd4
    } t_page;

    typedef enum logic [0:0] {
        REG_CODE_PAGE = 1'b0
    } t_reg_idx;

    function automatic logic in_rng8(input logic [7:0] v, input logic [7:0] lo,
                                     input logic [7:0] hi);
        return (v >= lo) && (v <= hi);
    endfunction

    function automatic logic in_rng16(input logic [15:0] v, input logic [15:0] lo,
                                      input logic [15:0] hi);
        return (v >= lo) && (v <= hi);
    endfunction

endpackage

// File: hw/rtl/dbcs_match.sv
// Per-code-page range tests for one lead/trail byte pair.
module dbcs_match
    import dbcs_pkg::*;
(
    input  t_page      i_page,
    input  logic [7:0] i_lead,
    input  logic [7:0] i_trail,
    output logic       o_sel
);

    function automatic logic gbk_unit(input logic [7:0] ld, input logic [7:0] tr,
                                      input logic [15:0] cv);
        logic sym;
        logic res;
        sym = in_rng16(cv, 16'hA6A1, 16'hA6B8) || in_rng16(cv, 16'hA6C1, 16'hA6D8) ||
              in_rng16(cv, 16'hA6E0, 16'hA6EB) || in_rng16(cv, 16'hA6EE, 16'hA6F2) ||
              in_rng16(cv, 16'hA6F4, 16'hA6F5) || in_rng16(cv, 16'hA7A1, 16'hA7C1) ||
              in_rng16(cv, 16'hA7D1, 16'hA7F1) || in_rng16(cv, 16'hA840, 16'hA895) ||
              in_rng16(cv, 16'hA8A1, 16'hA8BB) || in_rng16(cv, 16'hA8BD, 16'hA8BE) ||
              (cv == 16'hA8C1) || in_rng16(cv, 16'hA8C5, 16'hA8E9) ||
              in_rng16(cv, 16'hA940, 16'hA957) || in_rng16(cv, 16'hA959, 16'hA95A) ||
              (cv == 16'hA95C) || in_rng16(cv, 16'hA960, 16'hA988) ||
              (cv == 16'hA996);
        priority if (in_rng8(ld, 8'h81, 8'hA0) && in_rng8(tr, 8'h40, 8'hFE) &&
                     (tr != 8'h7F)) begin
            res = 1'b1;
        end else if (sym) begin
            res = (tr != 8'h7F);
        end else if (in_rng8(ld, 8'hAA, 8'hFC) && in_rng8(tr, 8'h40, 8'hA0) &&
                     (tr != 8'h7F)) begin
            res = 1'b1;
        end else if (in_rng16(cv, 16'hFE40, 16'hFE4F)) begin
            res = 1'b1;
        end else if (((ld == 8'hA1) || (ld == 8'hA3)) && in_rng8(tr, 8'hA1, 8'hFE)) begin
            res = 1'b1;
        end else if ((ld == 8'hA4) && in_rng8(tr, 8'hA1, 8'hF3)) begin
            res = 1'b1;
        end else if ((ld == 8'hA5) && in_rng8(tr, 8'hA1, 8'hF6)) begin
            res = 1'b1;
        end else begin
            res = in_rng8(ld, 8'hB0, 8'hF7) && in_rng8(tr, 8'hA1, 8'hFE);
        end
        return res;
    endfunction

    function automatic logic big5_unit(input logic [7:0] ld, input logic [7:0] tr);
        logic low;
        logic res;
        low = in_rng8(tr, 8'h40, 8'h7E);
        priority if (in_rng8(ld, 8'hA1, 8'hA2)) begin
            res = low || in_rng8(tr, 8'hA1, 8'hFE);
        end else if (ld == 8'hA3) begin
            res = low || in_rng8(tr, 8'hA1, 8'hBF) || (tr == 8'hE1);
        end else if (in_rng8(ld, 8'hA4, 8'hC5) || in_rng8(ld, 8'hC9, 8'hF9)) begin
            res = low || in_rng8(tr, 8'hA1, 8'hFE);
        end else begin
            res = (ld == 8'hC6) && low;
        end
        return res;
    endfunction

    function automatic logic sjis_unit(input logic [7:0] ld, input logic [7:0] tr,
                                       input logic [15:0] cv);
        logic low;
        logic res;
        low = in_rng8(tr, 8'h40, 8'h7E);
        unique case (ld)
            8'h81: res = in_rng16(cv, 16'h8140, 16'h81AC) ||
                         in_rng16(cv, 16'h81B8, 16'h81BF) ||
                         in_rng16(cv, 16'h81C8, 16'h81CE) ||
                         in_rng16(cv, 16'h81DA, 16'h81E8) ||
                         in_rng16(cv, 16'h81F0, 16'h81F7) || (cv == 16'h81FC);
            8'h82: res = in_rng16(cv, 16'h824F, 16'h8258) ||
                         in_rng16(cv, 16'h8260, 16'h8279) ||
                         in_rng16(cv, 16'h8281, 16'h829A) ||
                         in_rng16(cv, 16'h829F, 16'h82F1);
            8'h83: res = in_rng16(cv, 16'h8340, 16'h8396) ||
                         in_rng16(cv, 16'h839F, 16'h83B6) ||
                         in_rng16(cv, 16'h83BF, 16'h83D6);
            8'h84: res = in_rng16(cv, 16'h8440, 16'h8460) ||
                         in_rng16(cv, 16'h8470, 16'h8491) ||
                         in_rng16(cv, 16'h849F, 16'h84BE);
            8'h87: res = in_rng16(cv, 16'h8740, 16'h875D) ||
                         in_rng16(cv, 16'h875F, 16'h8775) || (cv == 16'h877E) ||
                         in_rng16(cv, 16'h8780, 16'h879C);
            8'h88: res = in_rng16(cv, 16'h889F, 16'h88FC);
            8'hEA: res = low || in_rng8(tr, 8'h80, 8'hA4);
            8'hED: res = low || in_rng8(tr, 8'h80, 8'hEC) || in_rng8(tr, 8'hEF, 8'hFC);
            8'hEE: res = low || in_rng8(tr, 8'h80, 8'hFC);
            8'hFC: res = in_rng8(tr, 8'h40, 8'h4B);
            default: begin
                if (in_rng8(ld, 8'h89, 8'h9F) || in_rng8(ld, 8'hE0, 8'hE9) ||
                    in_rng8(ld, 8'hFA, 8'hFB)) begin
                    res = low || in_rng8(tr, 8'h80, 8'hFC);
                end else begin
                    res = 1'b0;
                end
            end
        endcase
        return res;
    endfunction

    function automatic logic korean_unit(input logic [7:0] ld, input logic [7:0] tr);
        logic res;
        priority if (in_rng8(ld, 8'h81, 8'hC5)) begin
            res = in_rng8(tr, 8'h41, 8'h5A) || in_rng8(tr, 8'h60, 8'h7A) ||
                  in_rng8(tr, 8'h81, 8'hFE);
        end else if (ld == 8'hC6) begin
            res = in_rng8(tr, 8'h41, 8'h52) || in_rng8(tr, 8'hA1, 8'hFE);
        end else begin
            res = in_rng8(ld, 8'hC7, 8'hC8) && in_rng8(tr, 8'hA1, 8'hFE);
        end
        return res;
    endfunction

    logic [15:0] cv;

    assign cv = {i_lead, i_trail};

    always_comb begin
        unique case (i_page)
            PAGE_GBK:    o_sel = gbk_unit(i_lead, i_trail, cv);
            PAGE_BIG5:   o_sel = big5_unit(i_lead, i_trail);
            PAGE_SJIS:   o_sel = sjis_unit(i_lead, i_trail, cv);
            PAGE_KOREAN: o_sel = korean_unit(i_lead, i_trail);
            default:     o_sel = 1'b0;
        endcase
    end

endmodule

// File: hw/rtl/dbcs_code_unit_classifier.sv
// Double-byte code unit classifier: a lead and trail byte request in, one
// valid-character flag out. One request per cycle is sustained while the output is
// not stalled; each accepted request passes the input register, the range tests and
// the result register, with a single pass of byte compares between the registers.
// The code page is chosen by the code_page_select register at byte address 0
// (0 none, 1 GBK, 2 Big5, 3 Shift-JIS, 4 Korean; other values select nothing) and
// is to be written only while no request is in flight; the block does not enforce it.
module dbcs_code_unit_classifier
    import dbcs_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [7:0]        i_lead_byte,
    input  logic [7:0]        i_trail_byte,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic              o_unit_selected,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    logic [2:0] r_page;
    logic       r_s1_vld;
    logic [7:0] r_lead;
    logic [7:0] r_trail;
    logic       r_out_vld;
    logic       r_sel;
    logic       n_sel;
    logic       s1_adv;
    logic       reg_hit;

    assign reg_hit = (paddr[ADDR_W-1:2] == REG_CODE_PAGE);
    assign pready  = 1'b1;
    assign prdata  = reg_hit ? {{(DATA_W-3){1'b0}}, r_page} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_page <= PAGE_NONE;
        end else if (psel && penable && pwrite && reg_hit) begin
            r_page <= pwdata[2:0];
        end
    end

    assign s1_adv     = !r_out_vld || i_out_ready;
    assign o_in_ready = !r_s1_vld || s1_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_lead  <= i_lead_byte;
            r_trail <= i_trail_byte;
        end
    end

    dbcs_match u_match (
        .i_page  (t_page'(r_page)),
        .i_lead  (r_lead),
        .i_trail (r_trail),
        .o_sel   (n_sel)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (s1_adv) begin
            r_out_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && r_s1_vld) begin
            r_sel <= n_sel;
        end
    end

    assign o_out_valid     = r_out_vld;
    assign o_unit_selected = r_sel;

endmodule
